@@ rtl/kta_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kta_pkg
// Shared sizes, codes and the per-cell control bundle of the keyed table.
// ----------------------------------------------------------------------------
package kta_pkg;

  localparam int CAPACITY    = 16;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // fixed field widths on the ports
  localparam int KEY_FW   = 32;
  localparam int VAL_FW   = 32;
  localparam int INDEX_FW = 4;
  localparam int COUNT_FW = 5;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_REM  = 2'd1,
    OP_FIND = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  typedef struct packed {
    logic cmp_en;  // latch a fresh compare result
    logic live;    // cell lies below the live count
    logic load;    // take the write key/value
    logic shift;   // take the upper neighbor's entry
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/kta_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kta_cell
// One table slot: key and value, a key compare, and a hand-down path from
// the next slot up for closing a gap on remove.
// ----------------------------------------------------------------------------
module kta_cell
  import kta_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cell_ctrl_t             ctrl,
  input  wire logic [KEY_WIDTH-1:0]   cmp_key,
  input  wire logic [KEY_WIDTH-1:0]   wr_key,
  input  wire logic [VALUE_WIDTH-1:0] wr_val,
  input  wire logic [KEY_WIDTH-1:0]   nb_key,
  input  wire logic [VALUE_WIDTH-1:0] nb_val,
  output logic [KEY_WIDTH-1:0]        key,
  output logic [VALUE_WIDTH-1:0]      val,
  output logic                        hit
);

  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic                   hit_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      key_r <= wr_key;
      val_r <= wr_val;
    end else if (ctrl.shift) begin
      key_r <= nb_key;
      val_r <= nb_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else if (ctrl.cmp_en) begin
      hit_r <= ctrl.live && (key_r == cmp_key);
    end
  end

  assign key = key_r;
  assign val = val_r;
  assign hit = hit_r;

endmodule
`default_nettype wire

@@ rtl/kta_pick.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kta_pick
// Turns the row of cell hits into found flag, position and stored value.
// Live keys are distinct, so at most one hit is set and an OR merge works.
// ----------------------------------------------------------------------------
module kta_pick
  import kta_pkg::*;
(
  input  wire logic [CAPACITY-1:0]    hit,
  input  wire logic [VALUE_WIDTH-1:0] vals [CAPACITY],
  output logic                        found,
  output logic [IDX_W-1:0]            pos,
  output logic [VALUE_WIDTH-1:0]      val
);

  always_comb begin
    pos = '0;
    val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit[i]) begin
        pos = pos | IDX_W'(i);
        val = val | vals[i];
      end
    end
    found = |hit;
  end

endmodule
`default_nettype wire

@@ rtl/keyed_table_add_remove_find.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_table_add_remove_find
// Packed key/value table with add, remove and find over a row of slot cells.
// ----------------------------------------------------------------------------
// Channel  Dir  Signals                    Contents
// in       in   in_tvalid/tready/tdata/    tdata: key_hash, value
//               in_tuser                   tuser: op
// out      out  out_tvalid/tready/tdata/   tdata: index, value_out, count
//               out_tuser                  tuser: status
//
// Every cell compares its key in the accept cycle and registers its hit;
// the S_UPD state then commits the add, remove or find and loads the result
// register. The commit holds while an earlier result sits untaken, and no new item is taken until it commits.
// Reset clears the live count and the handshake state; slot contents stay
// unknown until written and are never read beyond the live count.
// ----------------------------------------------------------------------------
module keyed_table_add_remove_find
  import kta_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // [31:0] key_hash, [63:32] value
  input  wire logic [1:0]  in_tuser,   // [1:0] op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [3:0] index, [35:4] value_out, [40:36] count
  output logic [1:0]       out_tuser   // [1:0] status
);

  localparam int OUT_PAD = 48 - (INDEX_FW + VAL_FW + COUNT_FW);

  typedef enum logic {S_IDLE, S_UPD} state_t;

  state_t                 state_r;
  logic [1:0]             op_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [CNT_W-1:0]       count_r, count_nxt;

  logic                   out_valid_r;
  status_t                out_status_r, st_nxt;
  logic [INDEX_FW-1:0]    out_index_r, idx_nxt;
  logic [VAL_FW-1:0]      out_value_r, vout_nxt;
  logic [COUNT_FW-1:0]    out_count_r;

  logic                   in_acc, commit, add_ok, rem_ok;
  logic [KEY_WIDTH-1:0]   cmp_key;
  cell_ctrl_t             ctrl     [CAPACITY];
  logic [KEY_WIDTH-1:0]   cell_key [CAPACITY];
  logic [VALUE_WIDTH-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]    hit;
  logic                   found;
  logic [IDX_W-1:0]       pos;
  logic [VALUE_WIDTH-1:0] found_val;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign commit    = (state_r == S_UPD) && (!out_valid_r || out_tready);
  assign cmp_key   = KEY_WIDTH'(in_tdata[KEY_FW-1:0]);

  kta_pick u_pick (
    .hit   (hit),
    .vals  (cell_val),
    .found (found),
    .pos   (pos),
    .val   (found_val)
  );

  always_comb begin
    add_ok    = 1'b0;
    rem_ok    = 1'b0;
    st_nxt    = ST_MISS;
    idx_nxt   = '0;
    vout_nxt  = '0;
    count_nxt = count_r;
    case (op_r)
      OP_ADD: begin
        if (found) begin
          st_nxt = ST_DUP;
        end else if (count_r == CNT_W'(CAPACITY)) begin
          st_nxt = ST_FULL;
        end else begin
          add_ok    = 1'b1;
          st_nxt    = ST_OK;
          idx_nxt   = INDEX_FW'(count_r);
          count_nxt = count_r + 1'b1;
        end
      end
      OP_REM: begin
        if (found) begin
          rem_ok    = 1'b1;
          st_nxt    = ST_OK;
          idx_nxt   = INDEX_FW'(pos);
          vout_nxt  = VAL_FW'(found_val);
          count_nxt = count_r - 1'b1;
        end
      end
      OP_FIND: begin
        if (found) begin
          st_nxt   = ST_OK;
          idx_nxt  = INDEX_FW'(pos);
          vout_nxt = VAL_FW'(found_val);
        end
      end
      default: begin
        st_nxt = ST_MISS;
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    always_comb begin
      ctrl[g].cmp_en = in_acc;
      ctrl[g].live   = (CNT_W'(g) < count_r);
      ctrl[g].load   = commit && add_ok && (count_r == CNT_W'(g));
      ctrl[g].shift  = commit && rem_ok && (IDX_W'(g) >= pos);
    end

    if (g < CAPACITY - 1) begin : g_mid
      kta_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl[g]),
        .cmp_key (cmp_key),
        .wr_key  (key_r),
        .wr_val  (val_r),
        .nb_key  (cell_key[g+1]),
        .nb_val  (cell_val[g+1]),
        .key     (cell_key[g]),
        .val     (cell_val[g]),
        .hit     (hit[g])
      );
    end else begin : g_top
      // top slot has no upper neighbor; what it takes on a shift is dead
      kta_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl[g]),
        .cmp_key (cmp_key),
        .wr_key  (key_r),
        .wr_val  (val_r),
        .nb_key  (key_r),
        .nb_val  (val_r),
        .key     (cell_key[g]),
        .val     (cell_val[g]),
        .hit     (hit[g])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (commit) begin
            state_r <= S_IDLE;
            count_r <= count_nxt;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_tuser;
      key_r <= KEY_WIDTH'(in_tdata[KEY_FW-1:0]);
      val_r <= VALUE_WIDTH'(in_tdata[KEY_FW+VAL_FW-1:KEY_FW]);
    end
    if (commit) begin
      out_status_r <= st_nxt;
      out_index_r  <= idx_nxt;
      out_value_r  <= vout_nxt;
      out_count_r  <= COUNT_FW'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_count_r, out_value_r, out_index_r};

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("live count above capacity");

  a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> $onehot0(hit))
    else $error("more than one live slot matched the key");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && add_ok) |=> (count_r == $past(count_r) + 1'b1) && out_tvalid)
    else $error("successful add did not grow the table");

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives add, remove and find items into the keyed table, tracks the table
// contents on the side and checks every result item field by field.
// ----------------------------------------------------------------------------
module testbench;
  import kta_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         POOL_SZ   = 24;
  localparam int         PHASES    = 6;
  localparam int         PHASE_LEN = 200;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] value;
  } kt_op_t;

  typedef struct {
    status_t     status;
    logic [3:0]  index;
    logic [31:0] value;
    logic [4:0]  count;
  } kt_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // [31:0] key_hash, [63:32] value
  logic [1:0]  in_tuser = '0;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // [3:0] index, [35:4] value_out, [40:36] count
  logic [1:0]  out_tuser;       // [1:0] status

  kt_op_t      pending_ops[$];
  kt_result_t  expected_results[$];

  // shadow copy of the table
  logic [31:0] key_tab[CAPACITY];
  logic [31:0] val_tab[CAPACITY];
  int          tab_count = 0;

  bit          calm = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;
  int          errors = 0;
  logic [31:0] key_pool[POOL_SZ];

  int add_w[PHASES] = '{60, 25, 45, 70, 20, 40};
  int rem_w[PHASES] = '{15, 50, 30, 10, 55, 30};

  keyed_table_add_remove_find u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #1 clk = ~clk;

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // applies one item to the shadow table and returns the result it yields
  function automatic kt_result_t apply_table_op(kt_op_t it);
    kt_result_t r;
    bit         hit;
    int         pos;
    r.status = ST_MISS;
    r.index  = '0;
    r.value  = '0;
    hit = 1'b0;
    pos = 0;
    for (int i = 0; i < tab_count; i++) begin
      if (!hit && key_tab[i] == it.key) begin
        hit = 1'b1;
        pos = i;
      end
    end
    case (it.op)
      OP_ADD: begin
        if (hit) begin
          r.status = ST_DUP;
        end else if (tab_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          key_tab[tab_count] = it.key;
          val_tab[tab_count] = it.value;
          r.index  = tab_count[3:0];
          r.status = ST_OK;
          tab_count++;
        end
      end
      OP_REM: begin
        if (hit) begin
          r.index  = pos[3:0];
          r.value  = val_tab[pos];
          r.status = ST_OK;
          for (int i = pos; i < tab_count - 1; i++) begin
            key_tab[i] = key_tab[i + 1];
            val_tab[i] = val_tab[i + 1];
          end
          tab_count--;
        end
      end
      OP_FIND: begin
        if (hit) begin
          r.index  = pos[3:0];
          r.value  = val_tab[pos];
          r.status = ST_OK;
        end
      end
      default: ;  // unused code: miss, no change
    endcase
    r.count = tab_count[4:0];
    return r;
  endfunction

  // input side
  always @(posedge clk) begin
    kt_op_t it;
    bit     busy;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      busy = in_tvalid;
      if (in_tvalid && in_tready) begin
        it.op    = in_tuser;
        it.key   = in_tdata[31:0];
        it.value = in_tdata[63:32];
        expected_results.push_back(apply_table_op(it));
        busy = 1'b0;
      end
      if (!busy) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          it = pending_ops.pop_front();
          in_tdata  <= {it.value, it.key};
          in_tuser  <= it.op;
          in_tvalid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    kt_result_t e;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("result item with nothing outstanding");
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (out_tuser != e.status) begin
            $error("status expected %0d got %0d", e.status, out_tuser);
            errors++;
          end
          if (out_tdata[3:0] != e.index) begin
            $error("index expected %0d got %0d", e.index, out_tdata[3:0]);
            errors++;
          end
          if (out_tdata[35:4] != e.value) begin
            $error("value_out expected %h got %h", e.value, out_tdata[35:4]);
            errors++;
          end
          if (out_tdata[40:36] != e.count) begin
            $error("count expected %0d got %0d", e.count, out_tdata[40:36]);
            errors++;
          end
          if (out_tdata[47:41] != '0) begin
            $error("pad expected 0 got %h", out_tdata[47:41]);
            errors++;
          end
        end
        out_gap = pick_gap();
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic push_op(logic [1:0] op, logic [31:0] key, logic [31:0] value);
    kt_op_t it;
    it.op    = op;
    it.key   = key;
    it.value = value;
    pending_ops.push_back(it);
  endtask

  initial begin
    int          r;
    logic [1:0]  op;
    logic [31:0] key;

    // misses on an empty table
    push_op(OP_FIND, 32'h0000_0000, 32'hFFFF_FFFF);
    push_op(OP_REM, 32'hFFFF_FFFF, 32'h0000_0000);
    push_op(OP_UNUSED, 32'h1234_5678, 32'h9ABC_DEF0);
    // field extremes, duplicate add
    push_op(OP_ADD, 32'h0000_0000, 32'h0000_0000);
    push_op(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_op(OP_ADD, 32'h0000_0000, 32'h5555_5555);
    push_op(OP_FIND, 32'hFFFF_FFFF, 32'h0000_0000);
    push_op(OP_FIND, 32'h0000_0000, 32'hFFFF_FFFF);
    // fill up
    for (int i = 2; i < CAPACITY; i++)
      push_op(OP_ADD, 32'hA000_0000 + i, $urandom);
    // full table, then duplicate on a full table (duplicate wins)
    push_op(OP_ADD, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
    push_op(OP_ADD, 32'h0000_0000, 32'hAAAA_AAAA);
    push_op(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // remove the head, shift, then remove the tail
    push_op(OP_REM, 32'h0000_0000, 32'h0);
    push_op(OP_FIND, 32'hFFFF_FFFF, 32'h0);
    push_op(OP_REM, 32'hA000_0000 + CAPACITY - 1, 32'h0);
    push_op(OP_FIND, 32'hA000_0007, 32'h0);

    for (int p = 0; p < PHASES; p++) begin
      while (pending_ops.size() != 0) @(posedge clk);
      calm = (p == 3);
      for (int k = 0; k < POOL_SZ; k++) key_pool[k] = $urandom;
      if (p == 0) begin
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
      end
      for (int n = 0; n < PHASE_LEN; n++) begin
        r = $urandom_range(0, 99);
        if (r < 3) op = OP_UNUSED;
        else if (r < 3 + add_w[p]) op = OP_ADD;
        else if (r < 3 + add_w[p] + rem_w[p]) op = OP_REM;
        else op = OP_FIND;
        if ($urandom_range(0, 9) == 0) key = $urandom;
        else key = key_pool[$urandom_range(0, POOL_SZ - 1)];
        push_op(op, key, $urandom);
      end
    end

    while (pending_ops.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/kta_pkg.sv
rtl/kta_cell.sv
rtl/kta_pick.sv
rtl/keyed_table_add_remove_find.sv
tb/testbench.sv
